FILE: sv/lfbc_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and crc function for the link frame block crc checker
package lfbc_pkg;

   localparam int MAX_FRAME_BYTES    = 292;
   localparam int HEADER_BLOCK_BYTES = 8;
   localparam int DATA_BLOCK_BYTES   = 16;

   // reflected form of polynomial 0x3D65
   localparam logic [15:0] CRC_POLY_REFLECTED = 16'hA6BC;

   // result kinds
   localparam logic [1:0] KIND_PAYLOAD    = 2'd0;
   localparam logic [1:0] KIND_CHECK_OK   = 2'd1;
   localparam logic [1:0] KIND_CHECK_FAIL = 2'd2;
   localparam logic [1:0] KIND_DISCARD    = 2'd3;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       frame_start;
      logic [8:0] frame_length;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic [1:0] kind;
      logic       frame_end;
      logic       frame_ok;
   } rsp_type;

   // one byte through the reflected crc, lsb first
   function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {8'h00, data};
      for (int b = 0; b < 8; b++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY_REFLECTED;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

FILE: sv/lfbc_frame_fsm.sv
`timescale 1ns / 1ps
// frame state, block sequencing and block check for one byte per step
module lfbc_frame_fsm
   import lfbc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    step_en,
   input  req_type item,
   output rsp_type result
);

   localparam logic [1:0] PHASE_DATA    = 2'd0;
   localparam logic [1:0] PHASE_LOW     = 2'd1;
   localparam logic [1:0] PHASE_HIGH    = 2'd2;
   localparam logic [1:0] PHASE_DISCARD = 2'd3;

   localparam logic [8:0] MIN_LEN      = 9'(HEADER_BLOCK_BYTES + 2);
   localparam logic [8:0] MAX_LEN      = 9'(MAX_FRAME_BYTES);
   localparam logic [8:0] LAST_BLK_MAX = 9'(DATA_BLOCK_BYTES + 2);
   localparam logic [4:0] HDR_LEN      = 5'(HEADER_BLOCK_BYTES);
   localparam logic [4:0] DATA_LEN     = 5'(DATA_BLOCK_BYTES);

   logic [15:0] crc_ff, crc_in;
   logic [4:0]  pos_ff, pos_in;
   logic [4:0]  len_ff, len_in;
   logic [8:0]  rem_ff, rem_in;
   logic [1:0]  phase_ff, phase_in;
   logic        lcm_ff, lcm_in;
   logic        fail_ff, fail_in;

   logic [15:0] check;
   logic [8:0]  after;
   logic [8:0]  after_m2;
   logic [4:0]  pos_inc;
   logic        update;

   always_comb begin
      // frame start reloads everything before the byte is handled
      crc_in   = crc_ff;
      pos_in   = pos_ff;
      len_in   = len_ff;
      rem_in   = rem_ff;
      phase_in = phase_ff;
      lcm_in   = lcm_ff;
      fail_in  = fail_ff;
      if (item.frame_start) begin
         crc_in   = '0;
         pos_in   = '0;
         len_in   = HDR_LEN;
         lcm_in   = 1'b0;
         fail_in  = 1'b0;
         phase_in = PHASE_DATA;
         rem_in   = item.frame_length;
         if (item.frame_length < MIN_LEN || item.frame_length > MAX_LEN) begin
            phase_in = PHASE_DISCARD;
            fail_in  = 1'b1;
            if (item.frame_length == 9'd0) begin
               rem_in = 9'd1;
            end
         end
      end

      check    = ~crc_in;
      after    = rem_in - 9'd1;
      after_m2 = after - 9'd2;
      pos_inc  = pos_in + 5'd1;
      update   = (rem_in != 9'd0);

      result.out_byte  = item.data_byte;
      result.kind      = KIND_DISCARD;

      unique case (phase_in)
         PHASE_DATA: begin
            crc_in      = crc16_byte(crc_in, item.data_byte);
            result.kind = KIND_PAYLOAD;
            pos_in      = pos_inc;
            if (pos_inc >= len_in) begin
               phase_in = PHASE_LOW;
            end
         end
         PHASE_LOW: begin
            if (item.data_byte == check[7:0]) begin
               lcm_in      = 1'b1;
               result.kind = KIND_CHECK_OK;
               phase_in    = PHASE_HIGH;
            end else begin
               lcm_in      = 1'b0;
               result.kind = KIND_CHECK_FAIL;
               fail_in     = 1'b1;
               phase_in    = PHASE_DISCARD;
            end
         end
         PHASE_HIGH: begin
            if (lcm_in && item.data_byte == check[15:8]) begin
               result.kind = KIND_CHECK_OK;
               crc_in      = '0;
               pos_in      = '0;
               lcm_in      = 1'b0;
               if (after == 9'd0) begin
                  phase_in = PHASE_DATA;
               end else if (after <= 9'd2) begin
                  // one or two stray bytes after a block
                  phase_in = PHASE_DISCARD;
                  fail_in  = 1'b1;
               end else begin
                  phase_in = PHASE_DATA;
                  len_in   = (after <= LAST_BLK_MAX) ? after_m2[4:0] : DATA_LEN;
               end
            end else begin
               result.kind = KIND_CHECK_FAIL;
               fail_in     = 1'b1;
               phase_in    = PHASE_DISCARD;
            end
         end
         default: begin
            result.kind = KIND_DISCARD;
         end
      endcase

      rem_in           = after;
      result.frame_end = update && (after == 9'd0);
      result.frame_ok  = update && (after == 9'd0) && !fail_in;
      if (!update) begin
         // byte outside any frame
         result.kind = KIND_DISCARD;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff   <= '0;
         pos_ff   <= '0;
         len_ff   <= HDR_LEN;
         rem_ff   <= '0;
         phase_ff <= PHASE_DATA;
         lcm_ff   <= 1'b0;
         fail_ff  <= 1'b0;
      end else if (step_en && update) begin
         crc_ff   <= crc_in;
         pos_ff   <= pos_in;
         len_ff   <= len_in;
         rem_ff   <= rem_in;
         phase_ff <= phase_in;
         lcm_ff   <= lcm_in;
         fail_ff  <= fail_in;
      end
   end

   // in the data phase the block is never already complete
   a_pos_below_len: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PHASE_DATA |-> pos_ff < len_ff)
      else $error("block position reached block length in data phase");

   // a failed check marks the frame failed
   a_fail_sticks: assert property (@(posedge clock) disable iff (reset)
      step_en && result.kind == KIND_CHECK_FAIL |=> fail_ff)
      else $error("check failure did not mark frame failed");

   // frame_ok only with frame_end
   a_ok_with_end: assert property (@(posedge clock) disable iff (reset)
      step_en && result.frame_ok |-> result.frame_end && result.kind != KIND_CHECK_FAIL)
      else $error("frame_ok without clean frame end");

endmodule

FILE: sv/link_frame_block_crc_checker.sv
`timescale 1ns / 1ps
// top level of the link frame block crc checker
//
//   channel | ports                           | dir | payload
//   --------+---------------------------------+-----+-------------------------------------
//   request | req_valid req_stall req_payload | in  | data_byte, frame_start, frame_length
//   result  | rsp_valid rsp_stall rsp_payload | out | out_byte, kind, frame_end, frame_ok
//
// one item in, one item out; sustained rate is one item per cycle while rsp_stall is low
// path: input register, then crc/sequencer logic into the result register
// the byte-wise crc update and block sequencing settle in the single stage between registers
// reset (synchronous) empties both registers and returns the frame state to its idle values
// a stalled result holds; the input register keeps taking items while the result register
// has room, so req_stall only rises when both registers are full and rsp_stall is high
module link_frame_block_crc_checker
   import lfbc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_payload
);

   // input register
   logic    in_vld_ff, in_vld_in;
   req_type in_item_ff;

   // result register
   logic    out_vld_ff, out_vld_in;
   rsp_type out_item_ff;

   rsp_type step_result;
   logic    advance;
   logic    req_take;

   // item moves forward when the result register is empty or being drained
   assign advance   = in_vld_ff && (!out_vld_ff || !rsp_stall);
   assign req_stall = in_vld_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   assign in_vld_in  = req_take || (in_vld_ff && !advance);
   assign out_vld_in = advance || (out_vld_ff && rsp_stall);

   lfbc_frame_fsm u_fsm (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .item    (in_item_ff),
      .result  (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff <= req_payload;
      end
      if (advance) begin
         out_item_ff <= step_result;
      end
   end

   assign rsp_valid   = out_vld_ff;
   assign rsp_payload = out_item_ff;

endmodule
